// ----- src/gdd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdd_pkg: shared types and constants for the Gregorian day difference core
// Transaction structs, sequencer codes, calendar tables and divider constants.
// ----------------------------------------------------------------------------
package gdd_pkg;

  localparam int unsigned MAX_YEAR     = 9999;
  localparam int unsigned YEAR_W       = 14;
  localparam int unsigned MONTH_W      = 4;
  localparam int unsigned DAY_W        = 5;
  localparam int unsigned COUNT_W      = 23;
  localparam int unsigned DAYS_IN_YEAR = 365;

  // floor(y / 100) == (y * RECIP_100) >> RECIP_SH, exact for y < 43690
  localparam int unsigned RECIP_100    = 5243;
  localparam int unsigned RECIP_SH     = 19;
  localparam int unsigned RECIP_W      = 13;
  localparam int unsigned MULQ_W       = YEAR_W + RECIP_W;
  localparam int unsigned Q_W          = 8;   // (2^14 - 1) / 100 = 163

  localparam int unsigned DBM_W        = 9;
  localparam int unsigned DIY_W        = 9;
  localparam int unsigned LIMIT_W      = 17;

  typedef struct packed {
    logic [YEAR_W-1:0]  year_a;
    logic [MONTH_W-1:0] month_a;
    logic [DAY_W-1:0]   day_a;
    logic [YEAR_W-1:0]  year_b;
    logic [MONTH_W-1:0] month_b;
    logic [DAY_W-1:0]   day_b;
  } in_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] day_count;
    logic                      first_valid;
    logic                      second_valid;
  } out_t;

  // Checked date, already replaced by 0001-01-01 when illegal
  typedef struct packed {
    logic               valid;
    logic               leap;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [YEAR_W-1:0]  py;    // year - 1
    logic [Q_W-1:0]     qpy;   // (year - 1) / 100
  } prep_t;

  typedef struct packed {
    logic sub;
  } alu_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PREP,
    ST_MUL,
    ST_ACC
  } state_t;

  typedef enum logic [2:0] {
    STEP_YEARS,
    STEP_QUAD,
    STEP_CENT,
    STEP_QCENT,
    STEP_MONTH,
    STEP_DAY
  } step_t;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [DBM_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DBM_W-1:0] n;
    unique case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- src/gregorian_day_difference_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gregorian_day_difference_core: signed day count between two dates
// The result is registered after the last accumulation step of date B.
// No new transaction is taken while one is in progress; in_ready is high only while idle.
// Each date goes through one shared adder: divide, check, multiply, then six
// accumulation steps. A stalled result holds the last step.
// Reset (rst_n low, synchronous) returns to idle and drops out_valid.
// ----------------------------------------------------------------------------
module gregorian_day_difference_core
  import gdd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // Control state
  state_t state_r, state_nxt;
  step_t  step_r,  step_nxt;
  logic   sel_r,   sel_nxt;      // 0: date A, 1: date B
  logic   out_valid_r, out_valid_nxt;

  // Datapath registers
  in_t                in_r,   in_nxt;
  logic [Q_W-1:0]     q_r,    q_nxt;
  prep_t              prep_r, prep_nxt;
  logic               va_r,   va_nxt;
  logic               vb_r,   vb_nxt;
  logic [COUNT_W-1:0] prod_r, prod_nxt;
  logic [COUNT_W-1:0] acc_r,  acc_nxt;
  out_t               out_r,  out_nxt;

  // Current date fields
  logic [YEAR_W-1:0]  yraw;
  logic [MONTH_W-1:0] mraw;
  logic [DAY_W-1:0]   draw;
  logic [MULQ_W-1:0]  mulq;
  prep_t              prep_w;

  // Shared adder
  logic [COUNT_W-1:0] alu_b;
  logic [COUNT_W-1:0] alu_y;
  alu_ctl_t           alu_ctl;
  logic               adv_out;

  assign yraw = sel_r ? in_r.year_b  : in_r.year_a;
  assign mraw = sel_r ? in_r.month_b : in_r.month_a;
  assign draw = sel_r ? in_r.day_b   : in_r.day_a;

  // year / 100 by reciprocal multiply
  assign mulq = MULQ_W'(yraw) * MULQ_W'(RECIP_100);

  gdd_date_prep u_prep (
    .year  (yraw),
    .month (mraw),
    .day   (draw),
    .q100  (q_r),
    .prep  (prep_w)
  );

  // Operand for the current accumulation step
  always_comb begin
    unique case (step_r)
      STEP_YEARS: alu_b = prod_r;
      STEP_QUAD:  alu_b = COUNT_W'(prep_r.py >> 2);
      STEP_CENT:  alu_b = COUNT_W'(prep_r.qpy);
      STEP_QCENT: alu_b = COUNT_W'(prep_r.qpy >> 2);
      STEP_MONTH: alu_b = COUNT_W'(days_before(prep_r.month))
                          + COUNT_W'(prep_r.leap && (prep_r.month > MONTH_FEB));
      STEP_DAY:   alu_b = COUNT_W'(prep_r.day);
      default:    alu_b = '0;
    endcase
  end

  // Date A is subtracted and date B added, so the final sum is B - A.
  assign alu_ctl.sub = (step_r == STEP_CENT) ^ ~sel_r;

  gdd_alu u_alu (
    .a   (acc_r),
    .b   (alu_b),
    .ctl (alu_ctl),
    .y   (alu_y)
  );

  assign adv_out = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_YEARS;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r   <= in_nxt;
    q_r    <= q_nxt;
    prep_r <= prep_nxt;
    va_r   <= va_nxt;
    vb_r   <= vb_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r;
    in_nxt        = in_r;
    q_nxt         = q_r;
    prep_nxt      = prep_r;
    va_nxt        = va_r;
    vb_nxt        = vb_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    out_nxt       = out_r;
    in_ready      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          in_nxt    = in_data;
          sel_nxt   = 1'b0;
          acc_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        q_nxt     = Q_W'(mulq >> RECIP_SH);
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        prep_nxt = prep_w;
        if (sel_r) begin
          vb_nxt = prep_w.valid;
        end else begin
          va_nxt = prep_w.valid;
        end
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt  = COUNT_W'(prep_r.py) * COUNT_W'(DAYS_IN_YEAR);
        step_nxt  = STEP_YEARS;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (step_r != STEP_DAY) begin
          acc_nxt  = alu_y;
          step_nxt = step_t'(step_r + 3'd1);
        end else if (!sel_r) begin
          acc_nxt   = alu_y;
          sel_nxt   = 1'b1;
          state_nxt = ST_DIV;
        end else if (adv_out) begin
          out_nxt.day_count    = alu_y;
          out_nxt.first_valid  = va_r;
          out_nxt.second_valid = vb_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // An accepted transaction always starts with date A's divide step
  a_start_a: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_DIV) && !sel_r)
    else $error("accepted transaction did not start on date A");

  // Finishing date A hands over to date B
  a_a_to_b: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC && step_r == STEP_DAY && !sel_r) |=> (state_r == ST_DIV) && sel_r)
    else $error("date A did not hand over to date B");

  // Two replaced dates are both 0001-01-01
  a_both_bad: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.first_valid && !out_r.second_valid) |-> (out_r.day_count == '0))
    else $error("nonzero count for two illegal dates");

  // The checked year never exceeds the limit
  a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (LIMIT_W'(prep_r.py) < LIMIT_W'(MAX_YEAR)))
    else $error("checked year out of range");
`endif

endmodule
`default_nettype wire

// ----- src/gdd_date_prep.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdd_date_prep: date legality check and year terms
// Uses the registered year / 100 quotient to find leap years, checks the
// date, substitutes 0001-01-01 when illegal and forms (y-1) and (y-1)/100.
// ----------------------------------------------------------------------------
module gdd_date_prep
  import gdd_pkg::*;
(
  input  logic [YEAR_W-1:0]  year,
  input  logic [MONTH_W-1:0] month,
  input  logic [DAY_W-1:0]   day,
  input  logic [Q_W-1:0]     q100,
  output prep_t              prep
);

  logic [YEAR_W-1:0]  back;
  logic               rem0;
  logic               leap_raw;
  logic [DAY_W-1:0]   len;
  logic               year_ok;
  logic               month_ok;
  logic               day_ok;
  logic               ok;

  assign back     = YEAR_W'(q100 * YEAR_W'(100));
  assign rem0     = (back == year);
  // divisible by 4 and not 100, or by 400 (= by 100 with quotient divisible by 4)
  assign leap_raw = rem0 ? (q100[1:0] == 2'd0) : (year[1:0] == 2'd0);
  assign len      = month_len(month) + DAY_W'((month == MONTH_FEB) && leap_raw);

  assign year_ok  = (year != '0) && (LIMIT_W'(year) <= LIMIT_W'(MAX_YEAR));
  assign month_ok = (month >= MONTH_JAN) && (month <= MONTH_DEC);
  assign day_ok   = (day != '0) && (day <= len);
  assign ok       = year_ok && month_ok && day_ok;

  always_comb begin
    prep.valid = ok;
    if (ok) begin
      prep.leap  = leap_raw;
      prep.month = month;
      prep.day   = day;
      prep.py    = year - YEAR_W'(1);
      // (y-1)/100 drops by one only when y itself is a multiple of 100
      prep.qpy   = rem0 ? (q100 - Q_W'(1)) : q100;
    end else begin
      prep.leap  = 1'b0;
      prep.month = MONTH_JAN;
      prep.day   = DAY_W'(1);
      prep.py    = '0;
      prep.qpy   = '0;
    end
  end

endmodule
`default_nettype wire

// ----- src/gdd_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdd_alu: shared add/subtract unit
// One wrapping adder of the count width, reused for every accumulation step.
// ----------------------------------------------------------------------------
module gdd_alu
  import gdd_pkg::*;
(
  input  logic [COUNT_W-1:0] a,
  input  logic [COUNT_W-1:0] b,
  input  alu_ctl_t           ctl,
  output logic [COUNT_W-1:0] y
);

  assign y = ctl.sub ? (a - b) : (a + b);

endmodule
`default_nettype wire

// ----- test/gdd_day_diff_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdd_day_diff_checker: span predictor and result compare
// Watches both channels of the day difference core. Every accepted date pair
// is turned into an expected day count and validity flags. Every accepted
// result is checked field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module gdd_day_diff_checker
  import gdd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   mismatches,
  output int   awaiting,
  output int   pairs_seen,
  output int   spans_seen,
  output int   replaced_seen,
  output int   negative_seen
);

  localparam int MAX_PRINTED = 20;

  out_t span_q[$];

  function automatic int unsigned common_month_days(int unsigned m);
    case (m)
      2:           return 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic bit is_leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic bit is_legal(int unsigned y, int unsigned m, int unsigned d);
    int unsigned len;
    if (y < 1 || y > MAX_YEAR || m < 1 || m > 12) return 1'b0;
    len = common_month_days(m) + ((m == 2 && is_leap_year(y)) ? 1 : 0);
    return (d >= 1) && (d <= len);
  endfunction

  // 0001-01-01 is day 1
  function automatic int unsigned ordinal_day(int unsigned y, int unsigned m,
                                              int unsigned d);
    int unsigned py;
    int unsigned n;
    int unsigned k;
    py = y - 1;
    n  = DAYS_IN_YEAR * py + py / 4 - py / 100 + py / 400;
    for (k = 1; k < m; k++) n += common_month_days(k);
    if (m > 2 && is_leap_year(y)) n += 1;
    return n + d;
  endfunction

  function automatic out_t predict_span(in_t t);
    out_t        r;
    bit          ok_a;
    bit          ok_b;
    int unsigned na;
    int unsigned nb;
    int          diff;
    ok_a = is_legal(t.year_a, t.month_a, t.day_a);
    ok_b = is_legal(t.year_b, t.month_b, t.day_b);
    na   = ok_a ? ordinal_day(t.year_a, t.month_a, t.day_a) : ordinal_day(1, 1, 1);
    nb   = ok_b ? ordinal_day(t.year_b, t.month_b, t.day_b) : ordinal_day(1, 1, 1);
    diff = int'(nb) - int'(na);
    r.day_count    = diff[COUNT_W-1:0];
    r.first_valid  = ok_a;
    r.second_valid = ok_b;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      // results first, so a result never meets the pair accepted on the same edge
      if (out_valid && out_ready) begin
        spans_seen++;
        if (span_q.size() == 0) begin
          report_mismatch("unexpected transaction", $signed(out_data.day_count), 0);
        end else begin
          want = span_q.pop_front();
          if (out_data.day_count !== want.day_count)
            report_mismatch("day_count", $signed(out_data.day_count),
                            $signed(want.day_count));
          if (out_data.first_valid !== want.first_valid)
            report_mismatch("first_valid", out_data.first_valid, want.first_valid);
          if (out_data.second_valid !== want.second_valid)
            report_mismatch("second_valid", out_data.second_valid, want.second_valid);
        end
      end
      if (in_valid && in_ready) begin
        want = predict_span(in_data);
        span_q.push_back(want);
        pairs_seen++;
        if (!want.first_valid || !want.second_valid) replaced_seen++;
        if (want.day_count[COUNT_W-1]) negative_seen++;
      end
      awaiting = span_q.size();
    end
  end

endmodule

// ----- test/tb_gregorian_day_difference_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gregorian_day_difference_core: stimulus and verdict for the day count core
// Sends a directed set of date pairs, then random pairs, under changing
// sender and receiver idling and one long output hold-off. A separate checker
// predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_gregorian_day_difference_core;
  import gdd_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 3;
  localparam int RANDOM_PAIRS = 600;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int STALL_LIMIT  = 2000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES = 25;    // extra margin once the checker queue is empty
  localparam int unsigned YEAR_ALL_ONES = 2**YEAR_W - 1;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // idling percentages, changed by the stimulus between phases
  int send_idle_pct = 11;
  int recv_idle_pct = 47;
  bit hold_req      = 1'b0;
  int stall_cycles  = 0;

  int mismatches;
  int awaiting;
  int pairs_seen;
  int spans_seen;
  int replaced_seen;
  int negative_seen;

  always #CLK_HALF clk = ~clk;

  gregorian_day_difference_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  gdd_day_diff_checker span_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .mismatches    (mismatches),
    .awaiting      (awaiting),
    .pairs_seen    (pairs_seen),
    .spans_seen    (spans_seen),
    .replaced_seen (replaced_seen),
    .negative_seen (negative_seen)
  );

  // --------------------------------------------------------------------------
  // Receiver: random ready per cycle; on request it drops ready for a long
  // stretch so the core holds its result and backs up the input side.
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a hung handshake on either side ends the run.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic in_t pack_dates(int unsigned ya, int unsigned ma, int unsigned da,
                                     int unsigned yb, int unsigned mb, int unsigned db);
    in_t p;
    p.year_a  = YEAR_W'(ya);
    p.month_a = MONTH_W'(ma);
    p.day_a   = DAY_W'(da);
    p.year_b  = YEAR_W'(yb);
    p.month_b = MONTH_W'(mb);
    p.day_b   = DAY_W'(db);
    return p;
  endfunction

  // Mostly legal date; month-end days are favored, so a few land past the end.
  function automatic void pick_date(output int unsigned y, output int unsigned m,
                                    output int unsigned d);
    y = $urandom_range(1, MAX_YEAR);
    m = $urandom_range(1, 12);
    d = ($urandom_range(3) == 0) ? $urandom_range(28, 31) : $urandom_range(1, 28);
  endfunction

  // A date broken in at least one way: zero year, year past the limit, bad
  // month, day zero, or a February day that never exists.
  function automatic void pick_broken(output int unsigned y, output int unsigned m,
                                      output int unsigned d);
    pick_date(y, m, d);
    case ($urandom_range(4))
      0: y = 0;
      1: y = $urandom_range(MAX_YEAR + 1, YEAR_ALL_ONES);
      2: m = $urandom_range(1) ? 0 : $urandom_range(13, 15);
      3: d = 0;
      default: begin
        m = 2;
        d = $urandom_range(30, 31);
      end
    endcase
  endfunction

  // Year starts and ends, leap days, century years and years near the range limits.
  function automatic void pick_edge(output int unsigned y, output int unsigned m,
                                    output int unsigned d);
    case ($urandom_range(3))
      0:       y = $urandom_range(1, 2);
      1:       y = $urandom_range(MAX_YEAR - 1, MAX_YEAR);
      2:       y = 100 * $urandom_range(1, MAX_YEAR / 100);
      default: y = 4 * $urandom_range(1, MAX_YEAR / 4);
    endcase
    case ($urandom_range(2))
      0: begin
        m = 2;
        d = $urandom_range(28, 29);
      end
      1: begin
        m = 12;
        d = 31;
      end
      default: begin
        m = 1;
        d = 1;
      end
    endcase
  endfunction

  function automatic in_t random_pair();
    int unsigned ya, ma, da, yb, mb, db;
    int unsigned k;
    k = $urandom_range(99);
    pick_date(ya, ma, da);
    pick_date(yb, mb, db);
    if (k < 15) begin
      yb = ya;                          // short spans within one year
    end else if (k < 25) begin
      if ($urandom_range(1)) pick_broken(ya, ma, da);
      else pick_broken(yb, mb, db);
    end else if (k < 30) begin
      pick_broken(ya, ma, da);
      pick_broken(yb, mb, db);
    end else if (k < 40) begin
      pick_edge(ya, ma, da);
      pick_edge(yb, mb, db);
    end else if (k < 50) begin
      // raw field noise over the full widths
      ya = $urandom_range(YEAR_ALL_ONES);
      ma = $urandom_range(2**MONTH_W - 1);
      da = $urandom_range(2**DAY_W - 1);
      yb = $urandom_range(YEAR_ALL_ONES);
      mb = $urandom_range(2**MONTH_W - 1);
      db = $urandom_range(2**DAY_W - 1);
    end
    return pack_dates(ya, ma, da, yb, mb, db);
  endfunction

  // Optional idle gap, then hold the pair until the core takes it.
  task automatic offer_dates(input in_t pair);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pair;
    do @(posedge clk); while (!in_ready);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    in_t directed_q[$];
    int  i;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // widest spans in both directions
    directed_q.push_back(pack_dates(1, 1, 1, MAX_YEAR, 12, 31));
    directed_q.push_back(pack_dates(MAX_YEAR, 12, 31, 1, 1, 1));
    // leap rules: ordinary leap, 400-year leap, century non-leap, common year
    directed_q.push_back(pack_dates(2024, 3, 1, 2024, 2, 29));
    directed_q.push_back(pack_dates(2000, 2, 29, 2000, 3, 1));
    directed_q.push_back(pack_dates(1900, 2, 29, 1900, 3, 1));
    directed_q.push_back(pack_dates(2023, 2, 29, 2023, 3, 1));
    directed_q.push_back(pack_dates(2024, 2, 30, 2024, 1, 1));
    directed_q.push_back(pack_dates(2023, 2, 28, 2023, 3, 1));
    directed_q.push_back(pack_dates(2100, 2, 28, 2100, 3, 1));
    // year zero and year past the limit
    directed_q.push_back(pack_dates(0, 5, 5, 2020, 5, 5));
    directed_q.push_back(pack_dates(MAX_YEAR + 1, 1, 1, 2020, 1, 1));
    // every field all ones, then all zeros: both dates replaced, zero span
    directed_q.push_back(pack_dates(YEAR_ALL_ONES, 15, 31, YEAR_ALL_ONES, 15, 31));
    directed_q.push_back(pack_dates(0, 0, 0, 0, 0, 0));
    // month out of range on either side
    directed_q.push_back(pack_dates(2020, 0, 10, 2020, 13, 10));
    directed_q.push_back(pack_dates(2020, 15, 10, 2020, 14, 1));
    // day zero and day past the month end
    directed_q.push_back(pack_dates(2020, 4, 31, 2020, 4, 30));
    directed_q.push_back(pack_dates(2020, 6, 0, 2020, 1, 31));
    // same date, year boundaries, a familiar long span
    directed_q.push_back(pack_dates(1, 1, 1, 1, 1, 1));
    directed_q.push_back(pack_dates(1600, 12, 31, 1601, 1, 1));
    directed_q.push_back(pack_dates(MAX_YEAR, 12, 31, MAX_YEAR, 1, 1));
    directed_q.push_back(pack_dates(1970, 1, 1, 2038, 1, 19));

    foreach (directed_q[j]) offer_dates(directed_q[j]);

    for (i = 0; i < RANDOM_PAIRS; i++) begin
      if (i == RANDOM_PAIRS / 3) begin
        // receiver mostly ready, sender often idle
        send_idle_pct = 47;
        recv_idle_pct = 11;
      end else if (i == 2 * RANDOM_PAIRS / 3) begin
        // full rate both sides; park the receiver once while pairs keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
      end
      offer_dates(random_pair());
    end
    in_valid <= 1'b0;

    // let the checker see the last accepted pair before looking at its count
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d date pairs (directed and random), %0d day counts compared.",
             pairs_seen, spans_seen);
    $display("Pairs with a replaced date: %0d, negative spans: %0d, under mixed stalls.",
             replaced_seen, negative_seen);
    if (mismatches == 0 && awaiting == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
